// ===== rtl/asc85_pkg.sv =====
// asc85_pkg: shared types and constants for the ascii85 stream decoder
// used by asc85_front, asc85_fifo, asc85_back and ascii85_stream_decoder
// no dependencies
package asc85_pkg;

    // frame tracking phases
    typedef enum logic [1:0] {
        PH_WAIT_LT    = 2'd0,
        PH_WAIT_TILDE = 2'd1,
        PH_FRAME      = 2'd2
    } t_phase;

    // one decoded group handed from front to back
    // nbytes of zero marks a bare end marker
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        is_end;
    } t_cmd;

    // character codes
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // base-85 arithmetic
    localparam logic [6:0] RADIX       = 7'd85;
    localparam logic [2:0] LAST_DIGIT  = 3'd4;
    localparam logic [2:0] GROUP_BYTES = 3'd4;

    // padding with k 'u' digits turns acc into (acc + 1) * 85^k - 1,
    // k = 5 - n for n pending digits, scale taken modulo 2^32
    function automatic logic [31:0] pad_scale(input logic [2:0] n);
        logic [31:0] s;
        unique case (n)
            3'd0:    s = 32'd142085829;
            3'd1:    s = 32'd52200625;
            3'd2:    s = 32'd614125;
            3'd3:    s = 32'd7225;
            3'd4:    s = 32'd85;
            default: s = 32'd1;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/asc85_front.sv =====
// asc85_front: takes characters, tracks framing and builds base-85 groups
// emits one group transaction per finished group, 'z' or closer
// depends on asc85_pkg
module asc85_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_in_char,
    output logic             o_cmd_valid,
    output asc85_pkg::t_cmd  o_cmd
);

    asc85_pkg::t_phase r_phase, n_phase;
    logic [31:0]       r_acc, n_acc;
    logic [2:0]        r_count, n_count;

    logic [7:0]        w_digit;
    logic [31:0]       w_mac;
    logic [31:0]       w_pad;
    logic              w_is_digit;

    // datapath: one digit step or the closer padding step
    assign w_digit    = i_in_char - asc85_pkg::CH_BANG;
    assign w_is_digit = (i_in_char >= asc85_pkg::CH_BANG) && (i_in_char <= asc85_pkg::CH_U);
    assign w_mac      = (r_acc * 32'(asc85_pkg::RADIX)) + {24'd0, w_digit};
    assign w_pad      = ((r_acc + 32'd1) * asc85_pkg::pad_scale(r_count)) - 32'd1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_valid) begin
            unique case (r_phase)
                asc85_pkg::PH_WAIT_TILDE: begin
                    if (i_in_char == asc85_pkg::CH_TILDE) begin
                        n_phase = asc85_pkg::PH_FRAME;
                    end else if (i_in_char != asc85_pkg::CH_LT) begin
                        n_phase = asc85_pkg::PH_WAIT_LT;
                    end
                end
                asc85_pkg::PH_FRAME: begin
                    if (i_in_char == asc85_pkg::CH_TILDE) begin
                        n_phase = asc85_pkg::PH_WAIT_LT;
                    end
                end
                default: begin
                    n_phase = (i_in_char == asc85_pkg::CH_LT) ? asc85_pkg::PH_WAIT_TILDE
                                                              : asc85_pkg::PH_WAIT_LT;
                end
            endcase
        end
    end

    // accumulator, digit count and group transaction
    always_comb begin
        n_acc         = r_acc;
        n_count       = r_count;
        o_cmd_valid   = 1'b0;
        o_cmd.word    = w_mac;
        o_cmd.nbytes  = asc85_pkg::GROUP_BYTES;
        o_cmd.is_end  = 1'b0;
        if (i_valid) begin
            unique case (r_phase)
                asc85_pkg::PH_WAIT_TILDE: begin
                    if (i_in_char == asc85_pkg::CH_TILDE) begin
                        n_acc   = 32'd0;
                        n_count = 3'd0;
                    end
                end
                asc85_pkg::PH_FRAME: begin
                    priority if (i_in_char == asc85_pkg::CH_TILDE) begin
                        // closer: pad the partial group
                        o_cmd_valid  = 1'b1;
                        o_cmd.word   = w_pad;
                        o_cmd.nbytes = (r_count < 3'd2) ? 3'd0 : r_count - 3'd1;
                        o_cmd.is_end = 1'b1;
                        n_acc        = 32'd0;
                        n_count      = 3'd0;
                    end else if (i_in_char <= asc85_pkg::CH_SPACE) begin
                        n_acc = r_acc;
                    end else if (i_in_char == asc85_pkg::CH_Z) begin
                        // four zero bytes only at a group start
                        if (r_count == 3'd0) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.word  = 32'd0;
                            n_acc       = 32'd0;
                        end
                    end else if (w_is_digit) begin
                        if (r_count == asc85_pkg::LAST_DIGIT) begin
                            o_cmd_valid = 1'b1;
                            n_acc       = 32'd0;
                            n_count     = 3'd0;
                        end else begin
                            n_acc   = w_mac;
                            n_count = r_count + 3'd1;
                        end
                    end else begin
                        n_acc = r_acc;
                    end
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= asc85_pkg::PH_WAIT_LT;
            r_acc   <= 32'd0;
            r_count <= 3'd0;
        end else begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/asc85_fifo.sv =====
// asc85_fifo: short group queue between front and back
// flop storage, head visible while not empty
// depends on asc85_pkg
module asc85_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  asc85_pkg::t_cmd  i_cmd,
    input  logic             i_pop,
    output asc85_pkg::t_cmd  o_head,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    asc85_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [CW-1:0]   r_count;
    logic            w_wr, w_rd;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + AW'(1);
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/asc85_back.sv =====
// asc85_back: splits group transactions into byte results, high byte first
// holds the current group and presents one result at a time
// depends on asc85_pkg
module asc85_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  asc85_pkg::t_cmd  i_head,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [7:0]       o_out_byte,
    output logic             o_byte_valid,
    output logic             o_message_end,
    output logic             o_last
);

    asc85_pkg::t_cmd r_cmd;
    logic            r_busy;
    logic [1:0]      r_idx;
    logic [7:0]      w_sel;
    logic            w_take;

    // byte select
    always_comb begin
        unique case (r_idx)
            2'd0: w_sel = r_cmd.word[31:24];
            2'd1: w_sel = r_cmd.word[23:16];
            2'd2: w_sel = r_cmd.word[15:8];
            2'd3: w_sel = r_cmd.word[7:0];
        endcase
    end

    // result ports
    assign o_empty       = !r_busy;
    assign o_byte_valid  = (r_cmd.nbytes != 3'd0);
    assign o_out_byte    = o_byte_valid ? w_sel : 8'd0;
    assign o_message_end = r_cmd.is_end;
    assign o_last        = !o_byte_valid || ({1'b0, r_idx} == (r_cmd.nbytes - 3'd1));

    // load the next group when idle or when the last byte leaves
    assign w_take  = r_busy && i_pop;
    assign o_q_pop = !i_q_empty && (!r_busy || (w_take && o_last));

    // current group
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_head;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (w_take) begin
                if (o_last) begin
                    r_busy <= 1'b0;
                    r_idx  <= 2'd0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

endmodule

// ===== rtl/ascii85_stream_decoder.sv =====
// ascii85_stream_decoder: top level of the ascii85 stream decoder
// front, group queue and back; depends on asc85_pkg, asc85_front,
// asc85_fifo and asc85_back
//
//   channel   | ports                                   | accepted when
//   ----------+-----------------------------------------+----------------
//   input     | push, full, i_in_char                   | push & !full
//   result    | pop, empty, o_out_byte, o_byte_valid,    | pop & !empty
//             | o_message_end, o_last                   |
//
// a character is taken every cycle while full is low; a finished group
// passes the group queue and the back's group register; bytes leave at
// one per cycle while pop is high, so a run of 'z' (four bytes per character)
// fills the FIFO_DEPTH-entry group queue and raises full until it drains
// reset is synchronous and clears framing, accumulator, queue and back
module ascii85_stream_decoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_char,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_message_end,
    output logic       o_last
);

    logic            w_accept;
    logic            w_cmd_valid;
    asc85_pkg::t_cmd w_cmd;
    asc85_pkg::t_cmd w_head;
    logic            w_q_empty;
    logic            w_q_pop;

    assign w_accept = push && !full;

    // framing and group building
    asc85_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_in_char   (i_in_char),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    // group queue
    asc85_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_valid),
        .i_cmd   (w_cmd),
        .i_pop   (w_q_pop),
        .o_head  (w_head),
        .o_full  (full),
        .o_empty (w_q_empty)
    );

    // byte output
    asc85_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_q_empty     (w_q_empty),
        .o_q_pop       (w_q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_message_end (o_message_end),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    // a bare end marker is always the closing and final result
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_byte_valid) |-> (o_last && o_message_end))
        else $error("bare marker without end or last");

    // a waiting group is loaded into an idle back in the next cycle
    a_back_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_q_empty && empty) |=> !empty)
        else $error("queued group not loaded");

    // a full queue implies the back holds a result
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("queue full while back idle");
`endif

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for ascii85_stream_decoder
// predicts decoded bytes per accepted character and checks every result transaction
// depends on asc85_pkg and the ascii85_stream_decoder rtl
module testbench;

    localparam int          CYCLE_LIMIT  = 100000;
    localparam int          TOTAL_ITEMS  = 200;
    localparam int          TAIL_CYCLES  = 12;
    localparam logic [7:0]  CH_GT        = 8'h3E;

    // one expected result transaction
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       msg_end;
        logic       last;
    } t_byte_out;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       push       = 1'b0;
    logic       pop        = 1'b0;
    logic [7:0] i_in_char  = 8'h00;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_message_end;
    logic       o_last;

    // decoder state mirror
    logic [31:0]         acc   = '0;
    logic [2:0]          ndig  = '0;
    asc85_pkg::t_phase   phase = asc85_pkg::PH_WAIT_LT;

    t_byte_out expected_bytes[$];
    int        fail_count   = 0;
    int        cycle_count  = 0;
    int        sent_count   = 0;
    bit        steady       = 1'b0;
    int        rx_hold_req  = 0;
    int        rx_hold_left = 0;
    int        rx_stall     = 0;

    ascii85_stream_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_in_char     (i_in_char),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_message_end (o_message_end),
        .o_last        (o_last)
    );

    always #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // idle length: mostly none or short, sometimes long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // queue count bytes of word, high byte first
    function automatic void emit_bytes(input logic [31:0] word, input int count,
                                       input logic msg_end);
        for (int k = 0; k < count; k++)
            expected_bytes.push_back('{word[31 - 8 * k -: 8], 1'b1, msg_end,
                                       k == count - 1});
    endfunction

    // expected decoder behavior for one accepted character
    function automatic void decode_char(input logic [7:0] c);
        int n;
        case (phase)
            asc85_pkg::PH_WAIT_TILDE: begin
                if (c == asc85_pkg::CH_TILDE) begin
                    phase = asc85_pkg::PH_FRAME;
                    acc   = '0;
                    ndig  = '0;
                end else if (c != asc85_pkg::CH_LT) begin
                    phase = asc85_pkg::PH_WAIT_LT;
                end
            end
            asc85_pkg::PH_FRAME: begin
                if (c == asc85_pkg::CH_TILDE) begin
                    // pad partial group with 'u' digits
                    n = int'(ndig);
                    for (int i = n; i < 5; i++)
                        acc = acc * 32'(asc85_pkg::RADIX) + 32'(asc85_pkg::RADIX - 7'd1);
                    if (n < 2)
                        expected_bytes.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
                    else
                        emit_bytes(acc, n - 1, 1'b1);
                    acc   = '0;
                    ndig  = '0;
                    phase = asc85_pkg::PH_WAIT_LT;
                end else if (c <= asc85_pkg::CH_SPACE) begin
                    // whitespace and control characters skipped
                end else if (c == asc85_pkg::CH_Z) begin
                    // zero group shorthand only at a group start
                    if (ndig == 3'd0) begin
                        acc = '0;
                        emit_bytes(32'h0, int'(asc85_pkg::GROUP_BYTES), 1'b0);
                    end
                end else if (c >= asc85_pkg::CH_BANG && c <= asc85_pkg::CH_U) begin
                    acc  = acc * 32'(asc85_pkg::RADIX) + 32'(c - asc85_pkg::CH_BANG);
                    ndig = ndig + 3'd1;
                    if (ndig > asc85_pkg::LAST_DIGIT) begin
                        emit_bytes(acc, int'(asc85_pkg::GROUP_BYTES), 1'b0);
                        acc  = '0;
                        ndig = '0;
                    end
                end
            end
            default: phase = (c == asc85_pkg::CH_LT) ? asc85_pkg::PH_WAIT_TILDE
                                                     : asc85_pkg::PH_WAIT_LT;
        endcase
    endfunction

    // compare one result transaction with the oldest expectation
    task automatic check_byte();
        t_byte_out want;
        if (expected_bytes.size() == 0) begin
            $error("unexpected result: out_byte %0h", o_out_byte);
            fail_count++;
        end else begin
            want = expected_bytes.pop_front();
            if (o_out_byte !== want.data) begin
                $error("out_byte: expected %0h, got %0h", want.data, o_out_byte);
                fail_count++;
            end
            if (o_byte_valid !== want.valid) begin
                $error("byte_valid: expected %0b, got %0b", want.valid, o_byte_valid);
                fail_count++;
            end
            if (o_message_end !== want.msg_end) begin
                $error("message_end: expected %0b, got %0b", want.msg_end, o_message_end);
                fail_count++;
            end
            if (o_last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, o_last);
                fail_count++;
            end
        end
    endtask

    // result side: check, then decide next pop with stalls and hold-offs
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty)
                check_byte();
            if (rx_hold_req != 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                pop <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
                rx_stall = pick_gap();
            end
        end
    end

    // offer one character and wait until it is taken
    task automatic feed_char(input logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_in_char <= c;
        do @(posedge i_clk); while (full);
        decode_char(c);
        sent_count++;
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++)
            feed_char(s[i]);
    endtask

    // stop sending until every expected result has come
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // opener matching: stray '<', repeated '<', then entry
    task automatic test_framing();
        feed_text("<a<<~");
    endtask

    // zero shorthand, wraparound group, skipped and ignored characters
    task automatic test_groups();
        feed_char(asc85_pkg::CH_Z);
        feed_text("uu");
        feed_char(8'h00);
        feed_char(asc85_pkg::CH_U);
        feed_char(8'hFF);
        feed_char(asc85_pkg::CH_U);
        feed_char(asc85_pkg::CH_SPACE);
        feed_char(asc85_pkg::CH_Z);
        feed_char(asc85_pkg::CH_U);
    endtask

    // closers with zero, one and four pending digits
    task automatic test_closers();
        feed_text("~>");
        feed_text("<~!~");
        feed_text("<~uuuu~");
    endtask

    // receiver holds off while zero groups pile up behind it
    task automatic test_backpressure();
        steady = 1'b1;
        rx_hold_req = 300;
        feed_text("<~");
        repeat (16) feed_char(asc85_pkg::CH_Z);
        feed_char(asc85_pkg::CH_TILDE);
        steady = 1'b0;
        wait_drained();
    endtask

    // one random character for the body of a frame
    function automatic logic [7:0] frame_char();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12) return 8'($urandom_range(asc85_pkg::CH_BANG, asc85_pkg::CH_U));
        if (r == 12) return asc85_pkg::CH_BANG;
        if (r == 13) return asc85_pkg::CH_U;
        if (r < 16) return asc85_pkg::CH_Z;
        if (r == 16) return 8'($urandom_range(0, asc85_pkg::CH_SPACE));
        if (r == 17) return 8'($urandom_range(asc85_pkg::CH_U + 8'd1, 255));
        if (r == 18) return $urandom_range(0, 1) ? asc85_pkg::CH_LT : CH_GT;
        return 8'($urandom_range(0, 255));
    endfunction

    // random frames, most closed and some left open, plus noise and broken openers
    task automatic test_random_frames();
        int         body;
        int         pick;
        logic [7:0] c;
        while (sent_count < TOTAL_ITEMS) begin
            steady = ($urandom_range(0, 4) == 0);
            pick   = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 3)) feed_char(8'($urandom_range(0, 255)));
            end else if (pick == 1) begin
                feed_char(asc85_pkg::CH_LT);
                feed_char(8'($urandom_range(0, 255)));
            end
            feed_char(asc85_pkg::CH_LT);
            feed_char(asc85_pkg::CH_TILDE);
            body = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 24);
            repeat (body) begin
                c = frame_char();
                feed_char(c);
            end
            // most frames close, some stay open into the next opener
            if ($urandom_range(0, 9) != 0) begin
                feed_char(asc85_pkg::CH_TILDE);
                if ($urandom_range(0, 1))
                    feed_char(CH_GT);
            end
        end
        steady = 1'b0;
    endtask

    // main sequence
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_framing();
        test_groups();
        test_closers();
        test_backpressure();
        test_random_frames();
        wait_drained();
        if (fail_count == 0 && expected_bytes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/asc85_pkg.sv
rtl/asc85_front.sv
rtl/asc85_fifo.sv
rtl/asc85_back.sv
rtl/ascii85_stream_decoder.sv
tb/testbench.sv
